// ----- rtl/core/emgrma_pkg.sv -----
// Shared types and constants for the rectified moving-average envelope core.
// Used by emgrma_datapath and emg_rectified_moving_average_core.
package emgrma_pkg;

  localparam int LANES       = 8;
  localparam int LANE_W      = 3;
  localparam int WINDOW_MAX  = 16;
  localparam int POS_W       = 4;
  localparam int LEN_W       = 5;
  localparam int SAMPLE_W    = 8;
  localparam int LEVEL_W     = 8;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int FRAME_W     = LANES * SAMPLE_W;
  localparam int ADDR_W      = LANE_W + POS_W;

  localparam logic [LEN_W-1:0] RESET_WINDOW = 5'd10;
  localparam logic [LEN_W-1:0] LEN_MAX      = 5'd16;
  localparam logic [LEN_W-1:0] LEN_MIN      = 5'd1;

  // ceil(2^16 / len): exact quotient for any sum below 2^12 after >> 16
  localparam logic [RECIP_W-1:0] RECIP [0:WINDOW_MAX] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
    17'd10923, 17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,
    17'd5462,  17'd5042,  17'd4682,  17'd4370,  17'd4096
  };

  typedef logic [LEVEL_W-1:0] level_t;

  // Control from the sequencer to the datapath; all but issue, lane and
  // clr_sums are held steady for the whole of one frame
  typedef struct packed {
    logic                issue;
    logic [LANE_W-1:0]   lane;
    logic [POS_W-1:0]    rd_pos;
    logic [POS_W-1:0]    wr_pos;
    logic                evict;
    logic                full;
    logic [RECIP_W-1:0]  recip;
    logic                clr_sums;
  } dp_ctrl_t;

  // One finished lane level back to the sequencer
  typedef struct packed {
    logic              lvl_valid;
    logic [LANE_W-1:0] lvl_lane;
    level_t            level;
  } dp_stat_t;

endpackage

// ----- rtl/core/emgrma_datapath.sv -----
// Per-lane history memory, running sums and reciprocal-multiply averaging.
// Depends on emgrma_pkg; driven lane by lane by the core sequencer.
module emgrma_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  emgrma_pkg::dp_ctrl_t               ctrl,
  input  logic [emgrma_pkg::FRAME_W-1:0]     frame,
  output emgrma_pkg::dp_stat_t               stat
);

  // history memory: row = lane, column = ring position
  logic [emgrma_pkg::SAMPLE_W-1:0] hist [0:(1 << emgrma_pkg::ADDR_W)-1];
  logic [emgrma_pkg::SAMPLE_W-1:0] rd_data;
  logic [emgrma_pkg::SUM_W-1:0]    lane_sum [0:emgrma_pkg::LANES-1];

  logic                                b_valid;
  logic [emgrma_pkg::LANE_W-1:0]       b_lane;
  logic                                c_valid;
  logic [emgrma_pkg::LANE_W-1:0]       c_lane;
  logic [emgrma_pkg::SUM_W-1:0]        c_sum;
  logic                                d_valid;
  logic [emgrma_pkg::LANE_W-1:0]       d_lane;
  logic [emgrma_pkg::SUM_W+emgrma_pkg::RECIP_W-1:0] d_prod;

  logic [emgrma_pkg::SAMPLE_W-1:0] raw;
  logic [emgrma_pkg::SAMPLE_W-1:0] mag;
  logic [emgrma_pkg::SUM_W-1:0]    old_term;
  logic [emgrma_pkg::SUM_W-1:0]    sum_new;

  // Read the entry leaving the window (registered read data); write the new magnitude
  always_ff @(posedge clk) begin
    rd_data <= hist[{ctrl.lane, ctrl.rd_pos}];
    if (b_valid) begin
      hist[{b_lane, ctrl.wr_pos}] <= mag;
    end
  end

  // Rectify the lane sample and update its running sum
  always_comb begin
    raw      = frame[b_lane*emgrma_pkg::SAMPLE_W +: emgrma_pkg::SAMPLE_W];
    mag      = raw[emgrma_pkg::SAMPLE_W-1] ? (~raw + 8'd1) : raw;
    old_term = ctrl.evict ? {4'd0, rd_data} : '0;
    sum_new  = lane_sum[b_lane] - old_term + {4'd0, mag};
  end

  // Hold the running sums; clear on reset or window change
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr_sums) begin
      for (int i = 0; i < emgrma_pkg::LANES; i++) begin
        lane_sum[i] <= '0;
      end
    end else if (b_valid) begin
      lane_sum[b_lane] <= sum_new;
    end
  end

  // Advance the lane pipeline: read, update, multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= ctrl.issue;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_lane <= ctrl.lane;
    c_lane <= b_lane;
    c_sum  <= sum_new;
    d_lane <= c_lane;
    d_prod <= c_sum * ctrl.recip;
  end

  // Drop the fraction; zero during warm-up
  always_comb begin
    stat.lvl_valid = d_valid;
    stat.lvl_lane  = d_lane;
    stat.level     = ctrl.full ?
                     d_prod[emgrma_pkg::RECIP_SHIFT +: emgrma_pkg::LEVEL_W] : '0;
  end

  // A window never sums beyond sixteen full-scale magnitudes
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> sum_new <= 12'd2048)
    else $error("lane sum out of range");

  // Lanes finish in order, back to back
  a_lane_order: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_lane != 3'd0) |-> ($past(d_valid) && $past(d_lane) == d_lane - 3'd1))
    else $error("lane levels out of order");

endmodule

// ----- rtl/core/emg_rectified_moving_average_core.sv -----
// A request is accepted, the eight lanes are issued in turn, then the last lane is
// updated and multiplied, its level collected and the output register loaded.
// A new request is taken only after the last result has moved to the output register;
// the eight lanes share the history-memory port and the reciprocal multiplier. A
// finished result waits in the output register while the next request runs; a second
// one stalls the input. Reset (rst, synchronous): window_length = 10, fill and sums
// cleared, ring at 0; history memory holds no reset and its entries are used only once written.
// Top level of the EMG envelope core; depends on emgrma_pkg and emgrma_datapath.
module emg_rectified_moving_average_core (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // chan0_sample .. chan7_sample, 8 bits each
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // chan0_level .. chan7_level, 8 bits each
  output logic        m_tuser,   // window_full
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata  // window_length
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  logic [emgrma_pkg::LEN_W-1:0]   window_length;
  logic [emgrma_pkg::LEN_W-1:0]   fill_count;
  logic [emgrma_pkg::POS_W-1:0]   write_position;
  logic [emgrma_pkg::LEN_W-1:0]   len_eff;
  logic [emgrma_pkg::LEN_W-1:0]   fill_next;

  logic [emgrma_pkg::FRAME_W-1:0] frame;
  logic [emgrma_pkg::POS_W-1:0]   rd_pos;
  logic [emgrma_pkg::POS_W-1:0]   wr_pos;
  logic                           evict;
  logic                           full;
  logic [emgrma_pkg::RECIP_W-1:0] recip;
  logic [emgrma_pkg::LANE_W:0]    issue_cnt;
  emgrma_pkg::level_t             lvl_hold [0:emgrma_pkg::LANES-1];

  emgrma_pkg::dp_ctrl_t ctrl;
  emgrma_pkg::dp_stat_t stat;

  logic s_acc;
  logic last_lvl;
  logic out_load;

  // Clamp the window length into 1..16
  always_comb begin
    if (window_length < emgrma_pkg::LEN_MIN) begin
      len_eff = emgrma_pkg::LEN_MIN;
    end else if (window_length > emgrma_pkg::LEN_MAX) begin
      len_eff = emgrma_pkg::LEN_MAX;
    end else begin
      len_eff = window_length;
    end
    fill_next = (fill_count < len_eff) ? fill_count + 5'd1 : fill_count;
  end

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign last_lvl = stat.lvl_valid &&
                    (stat.lvl_lane == emgrma_pkg::LANE_W'(emgrma_pkg::LANES - 1));
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Window state: config write restarts warm-up and wins over a request, which otherwise advances the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= emgrma_pkg::RESET_WINDOW;
      fill_count     <= '0;
      write_position <= '0;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
      fill_count    <= '0;
    end else if (s_acc) begin
      fill_count     <= fill_next;
      write_position <= write_position + 4'd1;
    end
  end

  // Capture the request and the per-frame datapath controls
  always_ff @(posedge clk) begin
    if (s_acc) begin
      frame  <= s_tdata;
      wr_pos <= write_position;
      rd_pos <= write_position - len_eff[emgrma_pkg::POS_W-1:0];
      evict  <= (fill_count >= len_eff);
      full   <= (fill_next >= len_eff);
      recip  <= emgrma_pkg::RECIP[len_eff];
    end
  end

  // Sequence the lanes; memory accesses of one request end before the next starts
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            state     <= ST_RUN;
            issue_cnt <= '0;
          end
        end
        ST_RUN: begin
          if (!issue_cnt[emgrma_pkg::LANE_W]) begin
            issue_cnt <= issue_cnt + 4'd1;
          end
          if (last_lvl) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.issue    = (state == ST_RUN) && !issue_cnt[emgrma_pkg::LANE_W];
    ctrl.lane     = issue_cnt[emgrma_pkg::LANE_W-1:0];
    ctrl.rd_pos   = rd_pos;
    ctrl.wr_pos   = wr_pos;
    ctrl.evict    = evict;
    ctrl.full     = full;
    ctrl.recip    = recip;
    ctrl.clr_sums = cfg_we;
  end

  emgrma_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .frame (frame),
    .stat  (stat)
  );

  // Collect lane levels as they finish
  always_ff @(posedge clk) begin
    if (stat.lvl_valid) begin
      lvl_hold[stat.lvl_lane] <= stat.level;
    end
  end

  // Output register: load when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < emgrma_pkg::LANES; i++) begin
        m_tdata[i*emgrma_pkg::LEVEL_W +: emgrma_pkg::LEVEL_W] <= lvl_hold[i];
      end
      m_tuser <= full;
    end
  end

  // Fill count never passes the effective window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= len_eff)
    else $error("fill count beyond window");

  // The last lane level moves the sequencer to result hand-off
  a_done_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last_lvl) |=> (state == ST_DONE))
    else $error("missed end of frame");

  // Issue count stays within the lane count
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= 4'd8)
    else $error("issue count overrun");

endmodule

// ----- bench/emg_envelope_checker.sv -----
`timescale 1ns / 100ps
// Checker for the EMG envelope core: predicts levels and compares every result.
// Watches the request, result and configuration ports; depends on emgrma_pkg.
module emg_envelope_checker
  import emgrma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [FRAME_W-1:0] s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [FRAME_W-1:0] m_tdata,
  input  logic               m_tuser,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_wdata,
  output int                 pending,
  output int                 fault_count
);

  typedef struct packed {
    logic                       full;
    logic [LANES*LEVEL_W-1:0]   levels;
  } envelope_t;

  // Predicted block state
  logic [SAMPLE_W-1:0] history [LANES][WINDOW_MAX];
  logic [SUM_W-1:0]    lane_sum [LANES];
  logic [LEN_W-1:0]    fill;
  logic [POS_W-1:0]    write_pos;
  logic [LEN_W-1:0]    win_len;

  envelope_t awaited_envelopes [$];

  // Rectify one frame, slide every lane's window and return the levels it yields
  function automatic envelope_t advance_envelope(input logic [FRAME_W-1:0] frame);
    envelope_t           res;
    logic [LEN_W-1:0]    span;
    logic [POS_W-1:0]    oldest;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    quotient;
    logic                evict;
    span   = (win_len < LEN_MIN) ? LEN_MIN : (win_len > LEN_MAX) ? LEN_MAX : win_len;
    oldest = write_pos - span[POS_W-1:0];
    evict  = (fill >= span);
    for (int lane = 0; lane < LANES; lane++) begin
      raw = frame[lane*SAMPLE_W +: SAMPLE_W];
      mag = raw[SAMPLE_W-1] ? (~raw + 8'd1) : raw;
      if (evict) begin
        lane_sum[lane] = lane_sum[lane] - {4'd0, history[lane][oldest]};
      end
      history[lane][write_pos] = mag;
      lane_sum[lane] = lane_sum[lane] + {4'd0, mag};
    end
    write_pos = write_pos + 4'd1;
    if (fill < span) begin
      fill = fill + 5'd1;
    end
    res.full = (fill >= span);
    for (int lane = 0; lane < LANES; lane++) begin
      quotient = lane_sum[lane] / {7'd0, span};
      res.levels[lane*LEVEL_W +: LEVEL_W] = res.full ? quotient[LEVEL_W-1:0] : '0;
    end
    return res;
  endfunction

  // Track configuration, queue a prediction per request and check each result
  always @(posedge clk) begin : watch_channels
    envelope_t want;
    if (rst) begin
      for (int lane = 0; lane < LANES; lane++) begin
        lane_sum[lane] = '0;
        for (int pos = 0; pos < WINDOW_MAX; pos++) begin
          history[lane][pos] = '0;
        end
      end
      fill      = '0;
      write_pos = '0;
      win_len   = RESET_WINDOW;
      awaited_envelopes.delete();
    end else begin
      // a write restarts warm-up but keeps the ring position
      if (cfg_we) begin
        win_len = cfg_wdata;
        fill    = '0;
        for (int lane = 0; lane < LANES; lane++) begin
          lane_sum[lane] = '0;
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_envelopes.insert(awaited_envelopes.size(), advance_envelope(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (awaited_envelopes.size() == 0) begin
          $error("result with no request outstanding: levels %h, window_full %0d",
                 m_tdata, m_tuser);
          fault_count = fault_count + 1;
        end else begin
          want = awaited_envelopes[0];
          awaited_envelopes.delete(0);
          for (int lane = 0; lane < LANES; lane++) begin
            if (m_tdata[lane*LEVEL_W +: LEVEL_W] !== want.levels[lane*LEVEL_W +: LEVEL_W]) begin
              $error("chan%0d_level: expected %0d, actual %0d", lane,
                     want.levels[lane*LEVEL_W +: LEVEL_W], m_tdata[lane*LEVEL_W +: LEVEL_W]);
              fault_count = fault_count + 1;
            end
          end
          if (m_tuser !== want.full) begin
            $error("window_full: expected %0d, actual %0d", want.full, m_tuser);
            fault_count = fault_count + 1;
          end
        end
      end
    end
    pending <= awaited_envelopes.size();
  end

endmodule

// ----- bench/emg_rectified_moving_average_core_tb.sv -----
`timescale 1ns / 100ps
// Top of the EMG envelope bench: clock, reset, request and result traffic, verdict.
// Depends on emgrma_pkg, emg_rectified_moving_average_core and emg_envelope_checker.
module emg_rectified_moving_average_core_tb;
  import emgrma_pkg::*;

  localparam int RANDOM_FRAMES = 500;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_AFTER    = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  wire                s_tready;
  logic [FRAME_W-1:0] s_tdata   = '0;   // chan0_sample .. chan7_sample, 8 bits each
  wire                m_tvalid;
  logic               m_tready  = 1'b0;
  wire  [FRAME_W-1:0] m_tdata;          // chan0_level .. chan7_level, 8 bits each
  wire                m_tuser;          // window_full
  logic               cfg_we    = 1'b0;
  logic [LEN_W-1:0]   cfg_wdata = '0;   // window_length

  int pending;
  int fault_count;
  int sender_gap_pct   = 7;
  int receiver_gap_pct = 62;
  int accepted_frames  = 0;
  int hold_left        = 0;
  int quiet_cycles     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  emg_rectified_moving_average_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  emg_envelope_checker envelope_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fault_count(fault_count)
  );

  // Result side: random back-pressure, plus one long hold once the core is busy
  always @(posedge clk) begin
    if (rst) begin
      m_tready        <= 1'b0;
      accepted_frames <= 0;
      hold_left       <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        accepted_frames <= accepted_frames + 1;
      end
      if (hold_left != 0) begin
        m_tready  <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (s_tvalid && s_tready && accepted_frames == HOLD_AFTER) begin
        m_tready  <= 1'b0;
        hold_left <= HOLD_CYCLES;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_gap_pct);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one frame after a random gap and hold it until s_tready reads high
  task automatic send_frame(input logic [FRAME_W-1:0] frame);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= frame;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Wait until every result is back, then write the window length
  task automatic write_window(input logic [LEN_W-1:0] len);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FRAME_W-1:0] frame;
    logic [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]    len;
    int                  sent;
    int                  phase;
    int                  count;
    int                  pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner frames under the reset window: fill it, then slide past it
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       frame = '0;
        1, 8, 9: frame = {8{8'h80}};
        2, 10:   frame = {8{8'h7F}};
        3:       frame = {8{8'hFF}};
        4:       frame = {8{8'h01}};
        5:       frame = 64'hC0_40_81_01_FF_00_7F_80;
        6:       frame = {8{8'h55}};
        7:       frame = {8{8'hAA}};
        11:      frame = 64'h80_7F_80_7F_80_7F_80_7F;
        12:      frame = 64'h01_FF_02_FE_7E_82_00_80;
        default: frame = '0;
      endcase
      send_frame(frame);
    end
    s_tvalid <= 1'b0;

    // Random frames over a sequence of window settings, short runs break warm-up
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_FRAMES) begin
      case (phase)
        0:       len = RESET_WINDOW;
        1:       len = LEN_MIN;
        2:       len = LEN_MAX;
        3:       len = 5'd0;
        4:       len = 5'd31;
        5:       len = 5'd17;
        default: len = LEN_W'($urandom_range(0, 31));
      endcase
      write_window(len);
      count = (phase % 4 == 3) ? $urandom_range(1, 12) : $urandom_range(25, 70);
      if (sent < 170) begin
        sender_gap_pct   = 7;
        receiver_gap_pct = 62;
      end else if (sent < 340) begin
        sender_gap_pct   = 62;
        receiver_gap_pct = 7;
      end else begin
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
      end
      repeat (count) begin
        for (int lane = 0; lane < LANES; lane++) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0:       sample = 8'h80;
            1:       sample = 8'h7F;
            2:       sample = 8'h00;
            default: sample = SAMPLE_W'($urandom_range(0, 255));
          endcase
          frame[lane*SAMPLE_W +: SAMPLE_W] = sample;
        end
        send_frame(frame);
        sent = sent + 1;
      end
      s_tvalid <= 1'b0;
      phase = phase + 1;
    end

    // Drain outstanding results and let the core settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
